@@ design/pic_pkg.sv @@
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants for the inversion counter
// Field widths, count saturation limit and the front-to-back command beat.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int VAL_W   = 10;
  localparam int COUNT_W = 19;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // One classified input beat, as handed from the front to the back.
  typedef struct packed {
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;
    logic             map_we;   // sequence not full, first value in range: record its position
    logic             seq_we;   // sequence not full: store the second value
    logic             is_last;  // close the sequence and start the count
  } cmd_t;

endpackage

@@ design/permutation_inversion_counter_unit.sv @@
// ----------------------------------------------------------------------------
// permutation_inversion_counter_unit: Kendall tau distance of two permutations
// Counts inversions between two streamed permutations with a merge sort.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat per position i, carrying element i of each
//   permutation; is_last_i marks the final beat, and n is the beat count.
//   Loading runs at one beat per cycle while the queue is not full; a
//   four-deep command queue sits between the input classifier and the
//   engine. On the last beat the engine maps the second permutation
//   through the recorded positions (read the stored element, read its
//   position from the position memory, write it), then runs a bottom-up
//   merge sort: ceil(log2 n) passes, each with a setup step per run and a
//   read and a compare step per element, limited by the registered reads.
//   While this runs the input channel stalls once the queue fills.
//   Output channel: one beat with inversion_count_o, saturating at the
//   19-bit maximum. The result register holds while out_stall_i is high;
//   a later sequence can load meanwhile, and its sort waits only to post.
//   Reset clears the control state and pair count; memories are not
//   cleared, and position entries persist across sequences.
//   Pairs beyond MAX_LENGTH in one sequence are dropped.
// ----------------------------------------------------------------------------
module permutation_inversion_counter_unit #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pic_pkg::VAL_W-1:0]     first_value_i,
  input  logic [pic_pkg::VAL_W-1:0]     second_value_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pic_pkg::COUNT_W-1:0]   inversion_count_o
);
  import pic_pkg::*;

  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int QW = $bits(cmd_t) + CW;

  cmd_t          f_cmd, b_cmd;
  logic [CW-1:0] f_idx, b_idx;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_din, q_dout;

  // Front: classify each accepted beat
  pic_front #(
    .MAX_LENGTH (MAX_LENGTH),
    .CW         (CW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .is_last_i      (is_last_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .cmd_o          (f_cmd),
    .idx_o          (f_idx)
  );

  assign q_din = {f_cmd, f_idx};

  pic_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .empty_o (q_empty)
  );

  assign b_cmd = cmd_t'(q_dout[QW-1:CW]);
  assign b_idx = q_dout[CW-1:0];

  // Back: store, map, merge and post the count
  pic_back #(
    .MAX_LENGTH (MAX_LENGTH),
    .CW         (CW)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_pop_o           (q_pop),
    .cmd_i             (b_cmd),
    .idx_i             (b_idx),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .inversion_count_o (inversion_count_o)
  );

endmodule

@@ design/pic_front.sv @@
// ----------------------------------------------------------------------------
// pic_front: input classifier
// Tracks the pair index, flags range and overflow cases, pushes commands.
// ----------------------------------------------------------------------------
module pic_front #(
  parameter int MAX_LENGTH = 1024,
  parameter int CW         = $clog2(MAX_LENGTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pic_pkg::VAL_W-1:0]   first_value_i,
  input  logic [pic_pkg::VAL_W-1:0]   second_value_i,
  input  logic                        is_last_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output pic_pkg::cmd_t               cmd_o,
  output logic [CW-1:0]               idx_o
);
  import pic_pkg::*;

  logic [CW-1:0] count_q, count_d;
  logic          seq_we;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  assign seq_we = (32'(count_q) < MAX_LENGTH);

  always_comb begin
    cmd_o.first_value  = first_value_i;
    cmd_o.second_value = second_value_i;
    cmd_o.seq_we       = seq_we;
    cmd_o.map_we       = seq_we & (32'(first_value_i) < MAX_LENGTH);
    cmd_o.is_last      = is_last_i;
  end

  assign idx_o = count_q;

  always_comb begin
    count_d = count_q;
    if (q_push_o) begin
      if (is_last_i) begin
        count_d = '0;
      end else if (seq_we) begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

@@ design/pic_queue.sv @@
// ----------------------------------------------------------------------------
// pic_queue: command queue
// Four-entry FIFO between the front and the back.
// ----------------------------------------------------------------------------
module pic_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);
  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == (PW+1)'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign dout_o  = store_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - (PW+1)'(1);
      end
    end
  end

endmodule

@@ design/pic_back.sv @@
// ----------------------------------------------------------------------------
// pic_back: load, map and merge-sort engine
// Stores pairs, maps the second permutation, counts inversions by merging.
// ----------------------------------------------------------------------------
module pic_back #(
  parameter int MAX_LENGTH = 1024,
  parameter int CW         = $clog2(MAX_LENGTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  pic_pkg::cmd_t                 cmd_i,
  input  logic [CW-1:0]                 idx_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pic_pkg::COUNT_W-1:0]   inversion_count_o
);
  import pic_pkg::*;

  localparam int AW = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
  localparam int DW = (AW > VAL_W) ? AW : VAL_W;
  localparam int WW = CW + 1;
  localparam int EW = CW + 2;
  localparam int SW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MAP_RD  = 3'd1;
  localparam logic [2:0] S_MAP_LK  = 3'd2;
  localparam logic [2:0] S_MAP_WR  = 3'd3;
  localparam logic [2:0] S_RUN     = 3'd4;
  localparam logic [2:0] S_MRG_RD  = 3'd5;
  localparam logic [2:0] S_MRG_CMP = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  // Ping-pong sequence stores; seq1 holds the mapped sequence first.
  logic [DW-1:0] seq0 [MAX_LENGTH];
  logic [DW-1:0] seq1 [MAX_LENGTH];
  logic [AW-1:0] pmap [MAX_LENGTH];

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      n_q, n_d, i_q, i_d;
  logic [CW-1:0]      lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [CW-1:0]      a_q, a_d, b_q, b_d, k_q, k_d;
  logic [WW-1:0]      w_q, w_d;
  logic               src_q, src_d;
  logic [COUNT_W-1:0] total_q, total_d;
  logic               res_valid_q, res_valid_d;
  logic [COUNT_W-1:0] res_q, res_d;

  logic [DW-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;
  logic [AW-1:0] pmap_q;
  logic          inrange_q, inrange_d;
  logic [CW-1:0] addr_a, addr_b;

  logic          we0, we1, pmap_we;
  logic [CW-1:0] wa0, wa1;
  logic [DW-1:0] wd0, wd1;

  logic [DW-1:0] da, db, merged;
  logic          a_ok, b_ok, take_a;
  logic [CW-1:0] inc;
  logic [SW-1:0] sum;
  logic [EW-1:0] lw, l2w, nx_lo;
  logic [WW-1:0] w2;
  logic          res_free;

  assign addr_a = (state_q == S_MAP_RD) ? i_q : a_q;
  assign addr_b = b_q;

  always_ff @(posedge clk_i) begin
    rd0a_q <= seq0[addr_a[AW-1:0]];
    rd0b_q <= seq0[addr_b[AW-1:0]];
    if (we0) begin
      seq0[wa0[AW-1:0]] <= wd0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd1a_q <= seq1[addr_a[AW-1:0]];
    rd1b_q <= seq1[addr_b[AW-1:0]];
    if (we1) begin
      seq1[wa1[AW-1:0]] <= wd1;
    end
  end

  always_ff @(posedge clk_i) begin
    pmap_q <= pmap[rd0a_q[AW-1:0]];
    if (pmap_we) begin
      pmap[AW'(cmd_i.first_value)] <= idx_i[AW-1:0];
    end
  end

  // Merge datapath
  assign da     = src_q ? rd1a_q : rd0a_q;
  assign db     = src_q ? rd1b_q : rd0b_q;
  assign a_ok   = (a_q < mid_q);
  assign b_ok   = (b_q < hi_q);
  assign take_a = a_ok & (~b_ok | (da <= db));
  assign merged = take_a ? da : db;
  assign inc    = (!take_a && a_ok) ? (mid_q - a_q) : '0;
  assign sum    = SW'(total_q) + SW'(inc);

  // Run bounds from lo and width
  assign lw    = EW'(lo_q) + EW'(w_q);
  assign l2w   = EW'(lo_q) + EW'({w_q, 1'b0});
  assign nx_lo = l2w;
  assign w2    = {w_q[WW-2:0], 1'b0};

  assign res_free = ~res_valid_q | ~out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) & ~q_empty_i;
  assign pmap_we  = q_pop_o & cmd_i.map_we;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    i_d         = i_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    w_d         = w_q;
    src_d       = src_q;
    total_d     = total_q;
    inrange_d   = inrange_q;
    res_d       = res_q;
    res_valid_d = res_valid_q & out_stall_i;
    we0         = 1'b0;
    wa0         = idx_i;
    wd0         = DW'(cmd_i.second_value);
    we1         = 1'b0;
    wa1         = k_q;
    wd1         = merged;

    case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          we0 = cmd_i.seq_we;
          if (cmd_i.is_last) begin
            n_d     = cmd_i.seq_we ? (idx_i + CW'(1)) : idx_i;
            i_d     = '0;
            state_d = S_MAP_RD;
          end
        end
      end
      S_MAP_RD: begin
        state_d = S_MAP_LK;
      end
      S_MAP_LK: begin
        inrange_d = (32'(rd0a_q) < MAX_LENGTH);
        state_d   = S_MAP_WR;
      end
      S_MAP_WR: begin
        we1 = 1'b1;
        wa1 = i_q;
        wd1 = inrange_q ? DW'(pmap_q) : '0;
        i_d = i_q + CW'(1);
        if ((i_q + CW'(1)) == n_q) begin
          total_d = '0;
          w_d     = WW'(1);
          lo_d    = '0;
          src_d   = 1'b1;
          state_d = (n_q <= CW'(1)) ? S_FIN : S_RUN;
        end else begin
          state_d = S_MAP_RD;
        end
      end
      S_RUN: begin
        mid_d   = (lw < EW'(n_q)) ? lw[CW-1:0] : n_q;
        hi_d    = (l2w < EW'(n_q)) ? l2w[CW-1:0] : n_q;
        a_d     = lo_q;
        b_d     = (lw < EW'(n_q)) ? lw[CW-1:0] : n_q;
        k_d     = lo_q;
        state_d = S_MRG_RD;
      end
      S_MRG_RD: begin
        state_d = S_MRG_CMP;
      end
      S_MRG_CMP: begin
        // destination is the store opposite the source
        we0 = src_q;
        wa0 = k_q;
        wd0 = merged;
        we1 = ~src_q;
        total_d = (sum > SW'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
        if (take_a) begin
          a_d = a_q + CW'(1);
        end else begin
          b_d = b_q + CW'(1);
        end
        k_d = k_q + CW'(1);
        if ((k_q + CW'(1)) == hi_q) begin
          if (nx_lo >= EW'(n_q)) begin
            // pass complete
            lo_d  = '0;
            w_d   = w2;
            src_d = ~src_q;
            state_d = (w2 >= WW'(n_q)) ? S_FIN : S_RUN;
          end else begin
            lo_d    = nx_lo[CW-1:0];
            state_d = S_RUN;
          end
        end else begin
          state_d = S_MRG_RD;
        end
      end
      S_FIN: begin
        if (res_free) begin
          res_d       = total_q;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    i_q       <= i_d;
    lo_q      <= lo_d;
    mid_q     <= mid_d;
    hi_q      <= hi_d;
    a_q       <= a_d;
    b_q       <= b_d;
    k_q       <= k_d;
    w_q       <= w_d;
    src_q     <= src_d;
    inrange_q <= inrange_d;
    res_q     <= res_d;
  end

  assign out_valid_o       = res_valid_q;
  assign inversion_count_o = res_q;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: inversion counter testbench
// Streams pairs of permutations, predicts the Kendall tau distance of each
// sequence and checks every count the block posts, under random idling.
// ----------------------------------------------------------------------------
module tb_top;
  import pic_pkg::*;

  localparam int          MAX_LEN      = 1024;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          DRAIN_CYCLES = 2000;

  typedef logic [VAL_W-1:0] val_q_t[$];

  // Predicts counts from accepted beats and compares posted counts in order.
  class inversion_scoreboard;
    logic [VAL_W-1:0]   position_of [MAX_LEN];
    logic [VAL_W-1:0]   second_seen [MAX_LEN];
    logic [VAL_W-1:0]   rank [MAX_LEN];
    int unsigned        pair_count;
    logic [COUNT_W-1:0] counts_due [$];
    int unsigned        errors;

    function new();
      pair_count = 0;
      errors     = 0;
    endfunction

    function void note_pair(input logic [VAL_W-1:0] first, input logic [VAL_W-1:0] second,
                            input logic last);
      longint unsigned total;
      int unsigned     i;
      int unsigned     j;
      // beats past the sequence limit are dropped whole, map write included
      if (pair_count < MAX_LEN) begin
        position_of[first]      = VAL_W'(pair_count);
        second_seen[pair_count] = second;
        pair_count++;
      end
      if (last) begin
        for (i = 0; i < pair_count; i++) rank[i] = position_of[second_seen[i]];
        // only strictly decreasing pairs count, so repeats add nothing
        total = 0;
        for (i = 0; i < pair_count; i++) begin
          for (j = i + 1; j < pair_count; j++) begin
            if (rank[i] > rank[j]) total++;
          end
        end
        counts_due.push_back((total > COUNT_MAX) ? COUNT_MAX : COUNT_W'(total));
        pair_count = 0;
      end
    endfunction

    function void check_count(input logic [COUNT_W-1:0] actual);
      logic [COUNT_W-1:0] expected;
      if (counts_due.size() == 0) begin
        $display("%0t: unexpected count beat, expected none, actual %0d", $time, actual);
        errors++;
      end else begin
        expected = counts_due.pop_front();
        if (actual !== expected) begin
          $display("%0t: inversion_count mismatch, expected %0d, actual %0d",
                   $time, expected, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return counts_due.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [VAL_W-1:0]   first_value_i;
  logic [VAL_W-1:0]   second_value_i;
  logic               is_last_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [COUNT_W-1:0] inversion_count_o;

  inversion_scoreboard sb;

  // Idle rates in percent; the receiver rate is read in another process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold-off: requested once by the stimulus, counted here.
  logic hold_request = 1'b0;
  logic hold_done    = 1'b0;
  int   hold_left    = 0;

  int unsigned cycle_count = 0;

  // Sequence under construction, plus every position entry written so far.
  val_q_t seq_first;
  val_q_t seq_second;
  val_q_t known_vals;
  bit     pos_known [MAX_LEN];

  permutation_inversion_counter_unit #(
    .MAX_LENGTH(MAX_LEN)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .first_value_i    (first_value_i),
    .second_value_i   (second_value_i),
    .is_last_i        (is_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .inversion_count_o(inversion_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run limit: far above the slowest legal run, including the full-size sort.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: check each accepted count beat, then choose next stall.
  // Signals are read before this edge's updates land, so the handshake seen
  // here is the one the block saw.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_count(inversion_count_o);
      if (hold_request && !hold_done) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  function automatic val_q_t shuffled(val_q_t q);
    int               i;
    int               j;
    logic [VAL_W-1:0] t;
    for (i = q.size() - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    return q;
  endfunction

  function automatic void add_pair(input int first, input int second);
    seq_first.push_back(VAL_W'(first));
    seq_second.push_back(VAL_W'(second));
  endfunction

  // Offers the built sequence beat by beat; is_last rides on the final beat.
  // Valid is only lowered for a random gap, never around a stall.
  task automatic send_seq();
    int i;
    for (i = 0; i < seq_first.size(); i++) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i     <= 1'b1;
      first_value_i  <= seq_first[i];
      second_value_i <= seq_second[i];
      is_last_i      <= (i == seq_first.size() - 1);
      do @(posedge clk_i); while (in_stall_o);
      sb.note_pair(seq_first[i], seq_second[i], i == seq_first.size() - 1);
      if (i < MAX_LEN && !pos_known[seq_first[i]]) begin
        pos_known[seq_first[i]] = 1'b1;
        known_vals.push_back(seq_first[i]);
      end
    end
    seq_first.delete();
    seq_second.delete();
  endtask

  // Mostly true permutations (of 0..n-1 or of a random value set); the rest
  // are broken sequences with repeats. Second values always hit a written
  // position entry, from this sequence or an earlier one.
  task automatic build_random_seq();
    int n;
    int kind;
    int i;
    int pick;
    bit taken [MAX_LEN];
    seq_first.delete();
    seq_second.delete();
    n    = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 16);
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      for (i = 0; i < n; i++) begin
        if (kind < 3) begin
          seq_first.push_back(VAL_W'(i));
        end else begin
          do pick = $urandom_range(0, MAX_LEN - 1); while (taken[pick]);
          taken[pick] = 1'b1;
          seq_first.push_back(VAL_W'(pick));
        end
      end
      seq_first  = shuffled(seq_first);
      seq_second = seq_first;
      if (kind == 6) seq_second.reverse();
      else seq_second = shuffled(seq_second);
    end else begin
      for (i = 0; i < n; i++) begin
        if (kind == 7) seq_first.push_back(VAL_W'($urandom_range(0, 7)));
        else seq_first.push_back(VAL_W'($urandom_range(0, MAX_LEN - 1)));
      end
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) seq_second.push_back(seq_first[$urandom_range(0, n - 1)]);
        else seq_second.push_back(known_vals[$urandom_range(0, known_vals.size() - 1)]);
      end
    end
  endtask

  task automatic run_random(input int goal);
    int sent;
    sent = 0;
    while (sent < goal) begin
      build_random_seq();
      sent += seq_first.size();
      send_seq();
    end
  endtask

  initial begin
    int i;
    sb = new();
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    first_value_i  <= '0;
    second_value_i <= '0;
    is_last_i      <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 12;
    recv_idle_pct <= 80;

    // single-beat sequence: nothing to invert
    add_pair(5, 5);
    send_seq();
    // extreme values, same order then swapped
    add_pair(0, 0);
    add_pair(1023, 1023);
    send_seq();
    add_pair(0, 1023);
    add_pair(1023, 0);
    send_seq();
    // full reversal
    for (i = 0; i < 4; i++) add_pair(i, 3 - i);
    send_seq();
    // repeated first value: the later position wins
    add_pair(7, 7);
    add_pair(7, 8);
    add_pair(8, 7);
    send_seq();
    // repeated second value: ties do not count
    add_pair(1, 2);
    add_pair(2, 2);
    add_pair(3, 1);
    send_seq();
    // second value mapped through an entry left by an earlier sequence
    add_pair(100, 5);
    add_pair(101, 100);
    send_seq();
    // alternating bit patterns
    add_pair(682, 341);
    add_pair(341, 682);
    send_seq();

    run_random(85);

    // sender idles heavily, receiver lightly
    send_idle_pct = 80;
    recv_idle_pct <= 12;
    run_random(85);

    // no idling; one long receiver hold-off backs the block up to its input
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_request  <= 1'b1;
    run_random(90);

    // overflow: full-size reversal, then beats past the limit that are dropped
    for (i = 0; i < MAX_LEN; i++) seq_first.push_back(VAL_W'(i));
    seq_first  = shuffled(seq_first);
    seq_second = seq_first;
    seq_second.reverse();
    for (i = 0; i < 3; i++) begin
      add_pair($urandom_range(0, MAX_LEN - 1), $urandom_range(0, MAX_LEN - 1));
    end
    send_seq();
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected count
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
